[rtl/nearest_neighbor_sprite_scaler_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sprite scaler
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_SPRITE_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_SPRITE_SCALER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication under reset
`define NNSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication under reset
`define NNSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NNSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define NNSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/nnss_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite scaler package
// Field widths, register indexes, reset values and the pixel type.
// ----------------------------------------------------------------------------
package nnss_pkg;

  localparam int SIZE_W     = 7;
  localparam int AREA_W     = 9;
  localparam int COORD_W    = 10;
  localparam int CHAN_W     = 8;
  localparam int PROD_W     = AREA_W + SIZE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd4;

  // Reset values of the registers
  localparam logic [SIZE_W-1:0] RST_SPRITE_SIZE = 7'd16;
  localparam logic [AREA_W-1:0] RST_AREA_WIDTH  = 9'd200;
  localparam logic [AREA_W-1:0] RST_AREA_HEIGHT = 9'd200;
  localparam logic [AREA_W-1:0] RST_ORIGIN_X    = 9'd50;
  localparam logic [AREA_W-1:0] RST_ORIGIN_Y    = 9'd50;

  localparam logic [CHAN_W-1:0] ALPHA_THRESHOLD = 8'd127;

  // One stored sprite pixel, red in the low byte
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

endpackage

[rtl/nearest_neighbor_sprite_scaler.sv]
// ----------------------------------------------------------------------------
// Nearest-neighbour sprite scaler: loads are taken back to back, without busy.
// Step: busy through DIV (QW = clog2(MAX_SPRITE_SIZE) divider bits), READ and
// OUT; strobe in the same cycle busy drops, a new step may start there.
// Reset clears walk/pointer and registers; the sprite memory is not cleared.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_sprite_scaler_macros.svh"

module nearest_neighbor_sprite_scaler
  import nnss_pkg::*;
#(
  parameter int CANVAS_WIDTH    = 300,
  parameter int CANVAS_HEIGHT   = 440,
  parameter int MAX_SPRITE_SIZE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  opcode_i,
  input  logic [CHAN_W-1:0]     pixel_red_i,
  input  logic [CHAN_W-1:0]     pixel_green_i,
  input  logic [CHAN_W-1:0]     pixel_blue_i,
  input  logic [CHAN_W-1:0]     pixel_alpha_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output logic [COORD_W-1:0]    canvas_col_o,
  output logic [COORD_W-1:0]    canvas_row_o,
  output logic                  write_enable_o,
  output logic [CHAN_W-1:0]     out_red_o,
  output logic [CHAN_W-1:0]     out_green_o,
  output logic [CHAN_W-1:0]     out_blue_o,
  output logic                  last_pixel_o
);

  localparam int DEPTH  = MAX_SPRITE_SIZE * MAX_SPRITE_SIZE;
  localparam int QW     = (MAX_SPRITE_SIZE > 1) ? $clog2(MAX_SPRITE_SIZE) : 1;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW     = $clog2(DEPTH + 1);
  localparam int RW     = AREA_W + QW;
  localparam int MW     = QW + SIZE_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [SIZE_W-1:0]    sprite_size_q;
  logic [AREA_W-1:0]    area_width_q, area_height_q, origin_x_q, origin_y_q;
  logic [AREA_W-1:0]    col_q, row_q;
  logic [PW-1:0]        ptr_q;
  logic [AW-1:0]        addr_q;

  logic [SIZE_W-1:0]    size_eff;
  logic [AREA_W-1:0]    w_eff, h_eff;
  logic [2*SIZE_W-1:0]  size_sq;
  logic                 accept, step_go, load_go, load_we;
  logic                 wrap;
  logic [AREA_W-1:0]    col_start, row_start;
  logic [PROD_W-1:0]    prod_x, prod_y;
  logic [QW-1:0]        quo_x, quo_y;
  logic                 done_x, done_y;
  logic [MW-1:0]        addr_full;
  logic [COORD_W-1:0]   cx, cy;
  logic                 in_canvas, last;
  pixel_t               load_px, rd_px;

  // Take every configuration write at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sprite_size_q <= RST_SPRITE_SIZE;
      area_width_q  <= RST_AREA_WIDTH;
      area_height_q <= RST_AREA_HEIGHT;
      origin_x_q    <= RST_ORIGIN_X;
      origin_y_q    <= RST_ORIGIN_Y;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SPRITE_SIZE: sprite_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_AREA_WIDTH:  area_width_q  <= cfg_data_i;
        REG_AREA_HEIGHT: area_height_q <= cfg_data_i;
        REG_ORIGIN_X:    origin_x_q    <= cfg_data_i;
        REG_ORIGIN_Y:    origin_y_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the geometry to legal values
  always_comb begin
    if (sprite_size_q == '0) begin
      size_eff = SIZE_W'(1);
    end else if (int'(sprite_size_q) > MAX_SPRITE_SIZE) begin
      size_eff = SIZE_W'(MAX_SPRITE_SIZE);
    end else begin
      size_eff = sprite_size_q;
    end
    w_eff   = (area_width_q == '0) ? AREA_W'(1) : area_width_q;
    h_eff   = (area_height_q == '0) ? AREA_W'(1) : area_height_q;
    size_sq = (2*SIZE_W)'(size_eff) * (2*SIZE_W)'(size_eff);
  end

  assign busy_o  = state_q != ST_IDLE;
  assign accept  = start_i && !busy_o;
  assign step_go = accept && opcode_i;
  assign load_go = accept && !opcode_i;
  assign load_we = load_go && (int'(ptr_q) < int'(size_sq));

  // Restart the walk when it lies outside the rectangle
  assign wrap      = (col_q >= w_eff) || (row_q >= h_eff);
  assign col_start = wrap ? '0 : col_q;
  assign row_start = wrap ? '0 : row_q;
  assign prod_x    = PROD_W'(col_start) * PROD_W'(size_eff);
  assign prod_y    = PROD_W'(row_start) * PROD_W'(size_eff);

  nnss_div #(.QW(QW)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (step_go),
    .dividend_i (RW'(prod_x)),
    .divisor_i  (w_eff),
    .quotient_o (quo_x),
    .done_o     (done_x)
  );

  nnss_div #(.QW(QW)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (step_go),
    .dividend_i (RW'(prod_y)),
    .divisor_i  (h_eff),
    .quotient_o (quo_y),
    .done_o     (done_y)
  );

  assign addr_full = MW'(quo_y) * MW'(size_eff) + MW'(quo_x);

  assign load_px = '{alpha: pixel_alpha_i, blue: pixel_blue_i,
                     green: pixel_green_i, red: pixel_red_i};

  nnss_store #(.DEPTH(DEPTH), .ADDR_W(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (ptr_q[AW-1:0]),
    .wdata_i (load_px),
    .re_i    (state_q == ST_READ),
    .raddr_i (addr_q),
    .rdata_o (rd_px)
  );

  // Form the destination pixel
  assign cx        = COORD_W'(origin_x_q) + COORD_W'(col_q);
  assign cy        = COORD_W'(origin_y_q) + COORD_W'(row_q);
  assign in_canvas = (int'(cx) < CANVAS_WIDTH) && (int'(cy) < CANVAS_HEIGHT);
  assign last      = (col_q == w_eff - AREA_W'(1)) && (row_q == h_eff - AREA_W'(1));

  // Sequence one transaction; hold walk, pointer and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      col_q          <= '0;
      row_q          <= '0;
      ptr_q          <= '0;
      addr_q         <= '0;
      result_valid_o <= 1'b0;
      canvas_col_o   <= '0;
      canvas_row_o   <= '0;
      write_enable_o <= 1'b0;
      out_red_o      <= '0;
      out_green_o    <= '0;
      out_blue_o     <= '0;
      last_pixel_o   <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (load_we) begin
            ptr_q <= ptr_q + PW'(1);
          end
          if (step_go) begin
            col_q   <= col_start;
            row_q   <= row_start;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (done_x && done_y) begin
            addr_q  <= addr_full[AW-1:0];
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          result_valid_o <= 1'b1;
          canvas_col_o   <= cx;
          canvas_row_o   <= cy;
          write_enable_o <= (rd_px.alpha > ALPHA_THRESHOLD) && in_canvas;
          out_red_o      <= rd_px.red;
          out_green_o    <= rd_px.green;
          out_blue_o     <= rd_px.blue;
          last_pixel_o   <= last;
          // Advance the walk, rewind walk and pointer after the last pixel
          if (last) begin
            col_q <= '0;
            row_q <= '0;
            ptr_q <= '0;
          end else if (col_q + AREA_W'(1) >= w_eff) begin
            col_q <= '0;
            row_q <= row_q + AREA_W'(1);
          end else begin
            col_q <= col_q + AREA_W'(1);
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `NNSS_ASSERT_SAME(a_div_in_step, clk_i, rst_ni, 1'b1, done_x == done_y, "dividers out of step")
  `NNSS_ASSERT_NEXT(a_strobe_after_out, clk_i, rst_ni, state_q == ST_OUT, result_valid_o, "result strobe missing")
  `NNSS_ASSERT_SAME(a_strobe_idle, clk_i, rst_ni, result_valid_o, !busy_o, "result strobe while busy")
  `NNSS_ASSERT_NEXT(a_load_quiet, clk_i, rst_ni, load_go, !busy_o && !result_valid_o, "load transaction gave result")

endmodule

[rtl/nnss_div.sv]
// ----------------------------------------------------------------------------
// Iterative restoring divider
// One quotient bit per cycle; the quotient is known to fit in QW bits.
// ----------------------------------------------------------------------------
module nnss_div
  import nnss_pkg::*;
#(
  parameter int QW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [AREA_W+QW-1:0] dividend_i,
  input  logic [AREA_W-1:0]    divisor_i,
  output logic [QW-1:0]        quotient_o,
  output logic                 done_o
);

  localparam int RW = AREA_W + QW;
  localparam int CW = $clog2(QW + 1);

  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] dsr_q, dsr_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          fits;

  // Trial subtract of the shifted divisor
  always_comb begin
    fits  = rem_q >= dsr_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = dividend_i;
      dsr_d = RW'(divisor_i) << (QW - 1);
      quo_d = '0;
      cnt_d = '0;
    end else if (!done_o) begin
      rem_d = fits ? rem_q - dsr_q : rem_q;
      dsr_d = dsr_q >> 1;
      quo_d = QW'({quo_q, fits});
      cnt_d = cnt_q + CW'(1);
    end
  end

  // Hold the iteration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CW'(QW);
      rem_q <= '0;
      dsr_q <= '0;
      quo_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      rem_q <= rem_d;
      dsr_q <= dsr_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = cnt_q == CW'(QW);
  assign quotient_o = quo_q;

endmodule

[rtl/nnss_store.sv]
// ----------------------------------------------------------------------------
// Sprite pixel memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nnss_store
  import nnss_pkg::*;
#(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  pixel_t            wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output pixel_t            rdata_o
);

  pixel_t mem [DEPTH];
  pixel_t rdata_q;

  // Write the loaded pixel
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the sampled pixel
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Sprite scaler testbench
// Loads sprites, reconfigures the rectangle and checks every destination
// pixel against a local model of the sampling, walk and write-enable logic.
// ----------------------------------------------------------------------------
module testbench;
  import nnss_pkg::*;

  localparam int CANVAS_COLS   = 300;
  localparam int CANVAS_ROWS   = 440;
  localparam int SPRITE_MAX    = 64;
  localparam int STORE_DEPTH   = SPRITE_MAX * SPRITE_MAX;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 450;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               we;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               last;
  } dest_pixel_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_STEP} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    pixel_t                 px;
    logic                   typed;
    dest_pixel_t            want;
  } stim_row_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start_i        = 1'b0;
  logic                  opcode_i       = 1'b0;
  logic [CHAN_W-1:0]     pixel_red_i    = '0;
  logic [CHAN_W-1:0]     pixel_green_i  = '0;
  logic [CHAN_W-1:0]     pixel_blue_i   = '0;
  logic [CHAN_W-1:0]     pixel_alpha_i  = '0;
  logic                  cfg_valid_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  busy_o;
  logic                  cfg_ready_o;
  logic                  result_valid_o;
  logic [COORD_W-1:0]    canvas_col_o;
  logic [COORD_W-1:0]    canvas_row_o;
  logic                  write_enable_o;
  logic [CHAN_W-1:0]     out_red_o;
  logic [CHAN_W-1:0]     out_green_o;
  logic [CHAN_W-1:0]     out_blue_o;
  logic                  last_pixel_o;

  // Local copy of the registers and the walk state
  logic [SIZE_W-1:0] side_reg   = RST_SPRITE_SIZE;
  logic [AREA_W-1:0] width_reg  = RST_AREA_WIDTH;
  logic [AREA_W-1:0] height_reg = RST_AREA_HEIGHT;
  logic [AREA_W-1:0] org_x_reg  = RST_ORIGIN_X;
  logic [AREA_W-1:0] org_y_reg  = RST_ORIGIN_Y;
  pixel_t            sprite_mem [STORE_DEPTH];
  bit                loaded     [STORE_DEPTH];
  int unsigned       fill_ptr   = 0;
  int unsigned       walk_x     = 0;
  int unsigned       walk_y     = 0;

  dest_pixel_t expected_pixels[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned items_taken = 0;
  bit          gapless     = 1'b0;

  nearest_neighbor_sprite_scaler #(
    .CANVAS_WIDTH    (CANVAS_COLS),
    .CANVAS_HEIGHT   (CANVAS_ROWS),
    .MAX_SPRITE_SIZE (SPRITE_MAX)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .pixel_red_i    (pixel_red_i),
    .pixel_green_i  (pixel_green_i),
    .pixel_blue_i   (pixel_blue_i),
    .pixel_alpha_i  (pixel_alpha_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .canvas_col_o   (canvas_col_o),
    .canvas_row_o   (canvas_row_o),
    .write_enable_o (write_enable_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .last_pixel_o   (last_pixel_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic int unsigned sprite_side();
    if (side_reg == 0) return 1;
    if (side_reg > SPRITE_MAX) return SPRITE_MAX;
    return side_reg;
  endfunction

  function automatic int unsigned nonzero_extent(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SPRITE_SIZE: side_reg   = data[SIZE_W-1:0];
      REG_AREA_WIDTH:  width_reg  = data;
      REG_AREA_HEIGHT: height_reg = data;
      REG_ORIGIN_X:    org_x_reg  = data;
      REG_ORIGIN_Y:    org_y_reg  = data;
      default: ;
    endcase
  endfunction

  // Store a loaded pixel; report whether the store took it
  function automatic bit store_pixel(pixel_t p);
    int unsigned s;
    s = sprite_side();
    if (fill_ptr < s * s) begin
      sprite_mem[fill_ptr] = p;
      loaded[fill_ptr]     = 1'b1;
      fill_ptr++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Restart a walk left outside the rectangle, then map it onto the sprite
  function automatic int unsigned source_index();
    int unsigned s, w, h, sx, sy;
    s = sprite_side();
    w = nonzero_extent(width_reg);
    h = nonzero_extent(height_reg);
    if (walk_x >= w || walk_y >= h) begin
      walk_x = 0;
      walk_y = 0;
    end
    sx = (walk_x * s) / w;
    sy = (walk_y * s) / h;
    if (sx >= s) sx = s - 1;
    if (sy >= s) sy = s - 1;
    return sy * s + sx;
  endfunction

  // Produce one destination pixel and advance the walk
  function automatic dest_pixel_t scale_step();
    dest_pixel_t d;
    pixel_t      p;
    int unsigned w, h, cx, cy;
    p  = sprite_mem[source_index()];
    w  = nonzero_extent(width_reg);
    h  = nonzero_extent(height_reg);
    cx = org_x_reg + walk_x;
    cy = org_y_reg + walk_y;
    d.col   = COORD_W'(cx);
    d.row   = COORD_W'(cy);
    d.we    = (p.alpha > ALPHA_THRESHOLD) && cx < CANVAS_COLS && cy < CANVAS_ROWS;
    d.red   = p.red;
    d.green = p.green;
    d.blue  = p.blue;
    d.last  = (walk_x == w - 1) && (walk_y == h - 1);
    if (d.last) begin
      walk_x   = 0;
      walk_y   = 0;
      fill_ptr = 0;
    end else if (walk_x + 1 >= w) begin
      walk_x = 0;
      walk_y++;
    end else begin
      walk_x++;
    end
    return d;
  endfunction

  // ---------------------------------------------------------------- table rows

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int data);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_data = CFG_DATA_W'(data);
    return r;
  endfunction

  function automatic stim_row_t load_row(int red, int green, int blue, int alpha);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_LOAD;
    r.px.red   = CHAN_W'(red);
    r.px.green = CHAN_W'(green);
    r.px.blue  = CHAN_W'(blue);
    r.px.alpha = CHAN_W'(alpha);
    return r;
  endfunction

  function automatic stim_row_t step_row();
    stim_row_t r;
    r      = '0;
    r.kind = ROW_STEP;
    return r;
  endfunction

  function automatic stim_row_t step_want(int col, int rw, bit we, int red, int green,
                                          int blue, bit last);
    stim_row_t r;
    r            = step_row();
    r.typed      = 1'b1;
    r.want.col   = COORD_W'(col);
    r.want.row   = COORD_W'(rw);
    r.want.we    = we;
    r.want.red   = CHAN_W'(red);
    r.want.green = CHAN_W'(green);
    r.want.blue  = CHAN_W'(blue);
    r.want.last  = last;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = $urandom;
    // Bias alpha towards the opacity threshold and the extremes
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 5))
        0:       p.alpha = 8'd0;
        1:       p.alpha = 8'd126;
        2:       p.alpha = 8'd127;
        3:       p.alpha = 8'd128;
        4:       p.alpha = 8'd129;
        default: p.alpha = 8'd255;
      endcase
    end
    return p;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick_extent(int unsigned limit);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 6);
    if (r < 75) return 0;
    if (r < 87) return $urandom_range(7, 20);
    if (r < 93) return limit;
    return $urandom_range(21, 511);
  endfunction

  function automatic int unsigned pick_origin(int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 20);
    if (r < 70) return $urandom_range(span - 12, span + 12);
    if (r < 85) return $urandom_range(0, 511);
    return $urandom_range(500, 511);
  endfunction

  task automatic idle_cycles(input int unsigned n);
    if (n != 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold the item until the block takes it, then record what it causes
  task automatic issue_item(input logic op, input pixel_t px, input bit typed,
                            input dest_pixel_t want);
    dest_pixel_t d;
    start_i       <= 1'b1;
    opcode_i      <= op;
    pixel_red_i   <= px.red;
    pixel_green_i <= px.green;
    pixel_blue_i  <= px.blue;
    pixel_alpha_i <= px.alpha;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (op == OP_LOAD) begin
      void'(store_pixel(px));
    end else begin
      d = scale_step();
      expected_pixels.push_back(typed ? want : d);
    end
    items_taken++;
  endtask

  task automatic feed_load();
    issue_item(OP_LOAD, rand_pixel(), 1'b0, '0);
    idle_cycles(draw_gap());
  endtask

  // Load on until the pixel to be sampled has been written, then step;
  // once the item budget runs out, drop steps that would need more loads
  task automatic random_step();
    while (!loaded[source_index()] && items_taken < RANDOM_ITEMS) feed_load();
    if (loaded[source_index()]) begin
      issue_item(OP_STEP, rand_pixel(), 1'b0, '0);
      idle_cycles(draw_gap());
    end
  endtask

  // Drop requests, wait for outstanding pixels and let the block go quiet
  task automatic drain_and_settle();
    start_i     <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (expected_pixels.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register, then drop valid for a cycle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    apply_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string what, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    dest_pixel_t want;
    if (result_valid_o === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel at col %0d row %0d, expected none",
                 $time, canvas_col_o, canvas_row_o);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("canvas_col", want.col, canvas_col_o);
        check_field("canvas_row", want.row, canvas_row_o);
        check_field("write_enable", COORD_W'(want.we), COORD_W'(write_enable_o));
        check_field("out_red", COORD_W'(want.red), COORD_W'(out_red_o));
        check_field("out_green", COORD_W'(want.green), COORD_W'(out_green_o));
        check_field("out_blue", COORD_W'(want.blue), COORD_W'(out_blue_o));
        check_field("last_pixel", COORD_W'(want.last), COORD_W'(last_pixel_o));
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned s, w, h, pos, n, r;

    directed_rows = '{
      // defaults after reset: first pixel lands at the origin
      load_row(8'hff, 8'h00, 8'haa, 8'h80),
      step_want(50, 50, 1'b1, 8'hff, 8'h00, 8'haa, 1'b0),
      // one-pixel sprite and zero-sized rectangle at the canvas corner
      cfg_row(REG_SPRITE_SIZE, 1),
      cfg_row(REG_AREA_WIDTH, 0),
      cfg_row(REG_AREA_HEIGHT, 0),
      cfg_row(REG_ORIGIN_X, 0),
      cfg_row(REG_ORIGIN_Y, 0),
      load_row(8'h00, 8'hff, 8'h55, 8'h7f),               // store full: dropped
      step_want(0, 0, 1'b1, 8'hff, 8'h00, 8'haa, 1'b1),   // walk restarts, last
      load_row(8'h00, 8'hff, 8'h55, 8'h7f),
      step_want(0, 0, 1'b0, 8'h00, 8'hff, 8'h55, 1'b1),   // alpha at threshold
      cfg_row(REG_ORIGIN_X, 511),
      cfg_row(REG_ORIGIN_Y, 511),
      load_row(8'hff, 8'hff, 8'hff, 8'hff),
      step_want(511, 511, 1'b0, 8'hff, 8'hff, 8'hff, 1'b1),
      cfg_row(REG_ORIGIN_X, 299),
      cfg_row(REG_ORIGIN_Y, 439),
      load_row(8'h01, 8'h02, 8'h03, 8'h80),
      step_want(299, 439, 1'b1, 8'h01, 8'h02, 8'h03, 1'b1),
      cfg_row(REG_ORIGIN_X, 300),
      load_row(8'h12, 8'h34, 8'h56, 8'hff),
      step_want(300, 439, 1'b0, 8'h12, 8'h34, 8'h56, 1'b1),
      cfg_row(REG_ORIGIN_X, 0),
      cfg_row(REG_ORIGIN_Y, 440),
      step_want(0, 440, 1'b0, 8'h12, 8'h34, 8'h56, 1'b1),
      // writes past the register list change nothing
      cfg_row(REG_SPARE_FIRST, 511),
      cfg_row(REG_SPARE_LAST, 0),
      // oversized sprite clamps to the maximum, zero size to one
      cfg_row(REG_SPRITE_SIZE, 511),
      cfg_row(REG_ORIGIN_Y, 0),
      load_row(8'hab, 8'hcd, 8'hef, 8'h81),
      step_want(0, 0, 1'b1, 8'hab, 8'hcd, 8'hef, 1'b1),
      cfg_row(REG_SPRITE_SIZE, 0),
      step_want(0, 0, 1'b1, 8'hab, 8'hcd, 8'hef, 1'b1),
      // 2x2 sprite stretched over 3x2 across the canvas corner
      cfg_row(REG_SPRITE_SIZE, 2),
      cfg_row(REG_AREA_WIDTH, 3),
      cfg_row(REG_AREA_HEIGHT, 2),
      cfg_row(REG_ORIGIN_X, 298),
      cfg_row(REG_ORIGIN_Y, 438),
      load_row(8'h10, 8'h20, 8'h30, 8'hc0),
      load_row(8'h40, 8'h50, 8'h60, 8'h00),
      load_row(8'h70, 8'h80, 8'h90, 8'h7f),
      load_row(8'ha0, 8'hb0, 8'hc0, 8'h80),
      step_row(), step_row(), step_row(), step_row(), step_row(), step_row()
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          drain_and_settle();
          write_register(directed_rows[i].reg_idx, directed_rows[i].reg_data);
        end
        ROW_LOAD: begin
          issue_item(OP_LOAD, directed_rows[i].px, 1'b0, '0);
          idle_cycles(draw_gap());
        end
        default: begin
          issue_item(OP_STEP, directed_rows[i].px, directed_rows[i].typed,
                     directed_rows[i].want);
          idle_cycles(draw_gap());
        end
      endcase
    end

    // Random phases, each under a fresh configuration
    items_taken = 0;
    while (items_taken < RANDOM_ITEMS) begin
      drain_and_settle();
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 99);
        if (r < 55)      s = $urandom_range(1, 4);
        else if (r < 75) s = $urandom_range(5, 8);
        else if (r < 85) s = $urandom_range(9, 16);
        else if (r < 90) s = SPRITE_MAX;
        else if (r < 94) s = 0;
        else             s = $urandom_range(65, 127);
        write_register(REG_SPRITE_SIZE, {2'($urandom_range(0, 3)), 7'(s)});
      end
      if ($urandom_range(0, 9) < 7)
        write_register(REG_AREA_WIDTH, 9'(pick_extent(CANVAS_COLS)));
      if ($urandom_range(0, 9) < 7)
        write_register(REG_AREA_HEIGHT, 9'(pick_extent(CANVAS_ROWS)));
      if ($urandom_range(0, 9) < 7)
        write_register(REG_ORIGIN_X, 9'(pick_origin(CANVAS_COLS)));
      if ($urandom_range(0, 9) < 7)
        write_register(REG_ORIGIN_Y, 9'(pick_origin(CANVAS_ROWS)));
      if ($urandom_range(0, 9) == 0)
        write_register(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                       9'($urandom_range(0, 511)));
      cfg_valid_i <= 1'b0;
      gapless = ($urandom_range(0, 3) == 0);

      s = sprite_side();
      w = nonzero_extent(width_reg);
      h = nonzero_extent(height_reg);
      if ($urandom_range(0, 3) != 0) begin
        // Well-formed: fill a small sprite, then walk out a small rectangle
        if (s <= 8) begin
          n = (fill_ptr < s * s) ? s * s - fill_ptr : 0;
          repeat (n + $urandom_range(0, 2)) feed_load();
        end
        pos = (walk_x < w && walk_y < h) ? walk_y * w + walk_x : 0;
        n   = (w * h <= 64) ? w * h - pos : $urandom_range(1, 30);
        repeat (n) random_step();
      end else begin
        // Noise: loads and steps in any order, partial walks
        repeat ($urandom_range(1, 20)) begin
          if ($urandom_range(0, 9) < 4) feed_load();
          else random_step();
        end
      end
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/nnss_pkg.sv
rtl/nnss_div.sv
rtl/nnss_store.sv
rtl/nearest_neighbor_sprite_scaler.sv
bench/testbench.sv
